// ===== src/ilcs_pkg.sv =====
// Shared types and constants for the IPv4 / layer four checksum stream.
`timescale 1ns / 1ps
package ilcs_pkg;

	localparam int unsigned CountW = 17;
	localparam int unsigned HsumW  = 20;
	localparam int unsigned PsumW  = 32;

	localparam logic [CountW-1:0] HdrBytes = CountW'(20);
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [HsumW-1:0]  HsumMax  = {HsumW{1'b1}};
	localparam logic [PsumW-1:0]  PsumMax  = {PsumW{1'b1}};
	localparam logic [7:0]        ProtoUdp = 8'd17;

	localparam logic [CountW-1:0] PosLenHi = CountW'(2);
	localparam logic [CountW-1:0] PosLenLo = CountW'(3);
	localparam logic [CountW-1:0] PosProto = CountW'(9);

	localparam logic [1:0] StatOk       = 2'd0;
	localparam logic [1:0] StatShortLen = 2'd1;
	localparam logic [1:0] StatShortStr = 2'd2;

	// final sums of one packet, handed from accumulation to the finishing stage
	typedef struct packed {
		logic [HsumW-1:0] hsum;
		logic [PsumW-1:0] psum;
		logic             l4_en;
		logic             udp;
		logic [1:0]       status;
	} sums_t;

endpackage

// ===== src/ilcs_accum.sv =====
// Running header / layer four sums and end-of-packet sum register.
`timescale 1ns / 1ps
module ilcs_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat_valid,
	input  logic [7:0]        beat_byte,
	input  logic              beat_last,
	output logic              beat_take,
	output logic              sums_valid,
	output ilcs_pkg::sums_t   sums,
	input  logic              sums_take
);

	logic [ilcs_pkg::CountW-1:0] count_q, count_new;
	logic [ilcs_pkg::HsumW-1:0]  hsum_q, hsum_new, hsum_fin;
	logic [ilcs_pkg::PsumW-1:0]  psum_q, psum_new, psum_fin;
	logic [7:0]                  pend_q, pend_new, proto_q, proto_new;
	logic [15:0]                 tlen_q, tlen_new;
	logic [ilcs_pkg::HsumW:0]    hs_word, hs_odd;
	logic [ilcs_pkg::PsumW:0]    ps_word, ps_odd;
	logic [ilcs_pkg::CountW-1:0] tlen_ext, span_end;
	logic                        in_hdr, in_l4, hdr_odd, l4_odd, l4_en;
	logic [1:0]                  status;
	logic                        s2_free;
	ilcs_pkg::sums_t             sums_s2;
	logic                        valid_s2;

	assign tlen_ext = ilcs_pkg::CountW'(tlen_q);
	assign in_hdr   = count_q < ilcs_pkg::HdrBytes;
	assign in_l4    = !in_hdr && (count_q < tlen_ext);

	assign hs_word = {1'b0, hsum_q} + (ilcs_pkg::HsumW+1)'({beat_byte, pend_q});
	assign ps_word = {1'b0, psum_q} + (ilcs_pkg::PsumW+1)'({beat_byte, pend_q});

	always_comb begin
		tlen_new  = tlen_q;
		proto_new = proto_q;
		pend_new  = pend_q;
		hsum_new  = hsum_q;
		psum_new  = psum_q;
		if (in_hdr) begin
			if (count_q == ilcs_pkg::PosLenHi)
				tlen_new = {beat_byte, tlen_q[7:0]};
			else if (count_q == ilcs_pkg::PosLenLo)
				tlen_new = {tlen_q[15:8], beat_byte};
			else if (count_q == ilcs_pkg::PosProto)
				proto_new = beat_byte;
			if (!count_q[0])
				pend_new = beat_byte;
			else
				hsum_new = hs_word[ilcs_pkg::HsumW] ? ilcs_pkg::HsumMax
					: hs_word[ilcs_pkg::HsumW-1:0];
		end else if (in_l4) begin
			// offset from byte 20 has the same parity as the count
			if (!count_q[0])
				pend_new = beat_byte;
			else
				psum_new = ps_word[ilcs_pkg::PsumW] ? ilcs_pkg::PsumMax
					: ps_word[ilcs_pkg::PsumW-1:0];
		end
		count_new = (count_q == ilcs_pkg::CountMax) ? count_q : count_q + 1'b1;
	end

	// odd tail: the sum was left untouched this beat, so add to the old sum
	assign hs_odd = {1'b0, hsum_q} + (ilcs_pkg::HsumW+1)'(pend_new);
	assign ps_odd = {1'b0, psum_q} + (ilcs_pkg::PsumW+1)'(pend_new);

	assign l4_en    = ilcs_pkg::CountW'(tlen_new) >= ilcs_pkg::HdrBytes;
	assign span_end = (count_new < ilcs_pkg::CountW'(tlen_new)) ? count_new
		: ilcs_pkg::CountW'(tlen_new);
	assign hdr_odd  = (count_new < ilcs_pkg::HdrBytes) && count_new[0];
	assign l4_odd   = l4_en && (count_new > ilcs_pkg::HdrBytes) && span_end[0];

	always_comb begin
		hsum_fin = hsum_new;
		psum_fin = psum_new;
		if (hdr_odd)
			hsum_fin = hs_odd[ilcs_pkg::HsumW] ? ilcs_pkg::HsumMax
				: hs_odd[ilcs_pkg::HsumW-1:0];
		if (l4_odd)
			psum_fin = ps_odd[ilcs_pkg::PsumW] ? ilcs_pkg::PsumMax
				: ps_odd[ilcs_pkg::PsumW-1:0];
		if (!l4_en)
			status = ilcs_pkg::StatShortLen;
		else if (count_new < ilcs_pkg::CountW'(tlen_new))
			status = ilcs_pkg::StatShortStr;
		else
			status = ilcs_pkg::StatOk;
	end

	assign s2_free   = !valid_s2 || sums_take;
	assign beat_take = beat_valid && (!beat_last || s2_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hsum_q   <= '0;
			psum_q   <= '0;
			pend_q   <= '0;
			tlen_q   <= '0;
			proto_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (sums_take)
				valid_s2 <= 1'b0;
			if (beat_take) begin
				if (beat_last) begin
					count_q  <= '0;
					hsum_q   <= '0;
					psum_q   <= '0;
					pend_q   <= '0;
					tlen_q   <= '0;
					proto_q  <= '0;
					valid_s2 <= 1'b1;
				end else begin
					count_q <= count_new;
					hsum_q  <= hsum_new;
					psum_q  <= psum_new;
					pend_q  <= pend_new;
					tlen_q  <= tlen_new;
					proto_q <= proto_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_take && beat_last) begin
			sums_s2.hsum   <= hsum_fin;
			sums_s2.psum   <= psum_fin;
			sums_s2.l4_en  <= l4_en;
			sums_s2.udp    <= (proto_new == ilcs_pkg::ProtoUdp);
			sums_s2.status <= status;
		end
	end

	assign sums_valid = valid_s2;
	assign sums       = sums_s2;

endmodule

// ===== src/ilcs_finish.sv =====
// Folding, complement and UDP zero substitution, with the result register.
`timescale 1ns / 1ps
module ilcs_finish (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sums_valid,
	input  ilcs_pkg::sums_t sums,
	output logic            sums_take,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     header_checksum,
	output logic [15:0]     l4_checksum,
	output logic [1:0]      status
);

	logic [16:0] h1, h2, p1, p2, l1;
	logic [15:0] hdr_ck, l4_ck, l4_sel;
	logic        valid_q;
	logic [15:0] hdr_q, l4_q;
	logic [1:0]  status_q;

	assign h1     = 17'(sums.hsum[19:16]) + 17'(sums.hsum[15:0]);
	assign h2     = 17'(h1[16]) + 17'(h1[15:0]);
	assign hdr_ck = ~h2[15:0];

	assign p1     = 17'(sums.psum[31:16]) + 17'(sums.psum[15:0]);
	assign p2     = 17'(p1[16]) + 17'(p1[15:0]);
	assign l1     = 17'(p2[15:0]) + 17'(hdr_ck);
	assign l4_ck  = ~(l1[15:0] + 16'(l1[16]));

	always_comb begin
		if (!sums.l4_en)
			l4_sel = '0;
		else if (l4_ck == '0 && sums.udp)
			l4_sel = 16'hffff;
		else
			l4_sel = l4_ck;
	end

	assign sums_take = sums_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (sums_take)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (sums_take) begin
			hdr_q    <= hdr_ck;
			l4_q     <= l4_sel;
			status_q <= sums.status;
		end
	end

	assign out_valid       = valid_q;
	assign header_checksum = hdr_q;
	assign l4_checksum     = l4_q;
	assign status          = status_q;

endmodule

// ===== src/ipv4_l4_checksum_stream.sv =====
// Top level of the streaming IPv4 header and layer four checksum block.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+---------------------------------
//  in      | in_valid, in_ready, data_byte, last        | one packet byte, last on final
//  out     | out_valid, out_ready, header_checksum,     | one result per packet
//          | l4_checksum, status                        |
//
// One byte per cycle sustained. A byte sits in the input register, is
// folded into the running sums, and on the last byte the final sums go to a
// second register; from there the checksums are registered in the output
// register, which holds the result until out_ready takes it.
// Reset clears the running sums, counts and valid flags; the block then waits for a
// header byte. A stalled output only holds back last bytes behind a full
// sum register; ordinary bytes keep flowing.
`timescale 1ns / 1ps
module ipv4_l4_checksum_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] header_checksum,
	output logic [15:0] l4_checksum,
	output logic [1:0]  status
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            take_s1;
	logic            sums_valid;
	logic            sums_take;
	ilcs_pkg::sums_t sums;

	// input register frees up whenever its beat is consumed
	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	ilcs_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (valid_s1),
		.beat_byte  (byte_s1),
		.beat_last  (last_s1),
		.beat_take  (take_s1),
		.sums_valid (sums_valid),
		.sums       (sums),
		.sums_take  (sums_take)
	);

	ilcs_finish u_finish (
		.clk             (clk),
		.arst_n          (arst_n),
		.sums_valid      (sums_valid),
		.sums            (sums),
		.sums_take       (sums_take),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.header_checksum (header_checksum),
		.l4_checksum     (l4_checksum),
		.status          (status)
	);

endmodule

// ===== test/ipv4_l4_checksum_stream_tb.sv =====
// Self-checking testbench for the streaming IPv4 / layer four checksum block.
`timescale 1ns / 1ps
module ipv4_l4_checksum_stream_tb;

	// Run limit in cycles, above the slowest legal run (about two thousand beats,
	// both sides stalling).
	localparam int unsigned RunLimit = 50_000;
	// Cycles given to the pipeline after the last expected result.
	localparam int unsigned DrainCycles = 12;
	// Chance in a hundred that either side idles on a given cycle.
	localparam int unsigned IdlePct = 23;
	// Window of cycles in which neither side idles.
	localparam int unsigned QuietFrom = 1200;
	localparam int unsigned QuietTo   = 1700;
	localparam int unsigned RandomBeats = 1070;
	localparam int NumRows = 20;

	// One result beat: both checksums and the status code.
	typedef struct packed {
		logic [15:0] hdr;
		logic [15:0] l4;
		logic [1:0]  st;
	} csum_t;

	// One input beat, with a hand-worked result attached to some last beats.
	typedef struct packed {
		logic [7:0] data;
		logic       lst;
		logic       typed;
		csum_t      want;
	} byte_beat_t;

	// Directed packet: length in bytes, total length and protocol fields,
	// filler for the other header bytes and a word repeated over the payload.
	// With rnd set, every byte other than the length and protocol is random.
	typedef struct packed {
		logic [17:0] len;
		logic [15:0] tl;
		logic [7:0]  pr;
		logic [7:0]  hf;
		logic [15:0] pw;
		logic        rnd;
		logic        typed;
		csum_t       want;
	} row_t;

	// Rows with typed results first: all-zero, all-ones, exact header only,
	// length just below the header, a one-byte short stream, and the UDP /
	// TCP pair whose checksum comes out zero.  The rest are checked against
	// the predictor: odd header tails, a stream cut inside the length field,
	// odd payload tails, bytes past the total length, and a long packet.
	row_t dir_rows [NumRows] = '{
		'{18'd1,    16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1,
			'{16'hffff, 16'h0000, ilcs_pkg::StatShortLen}},
		'{18'd20,   16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1,
			'{16'hffff, 16'h0000, ilcs_pkg::StatShortLen}},
		'{18'd20,   16'hffff, 8'hff, 8'hff, 16'hffff, 1'b0, 1'b1,
			'{16'h0000, 16'hffff, ilcs_pkg::StatShortStr}},
		'{18'd20,   16'd20,   8'h00, 8'h00, 16'h0000, 1'b0, 1'b1,
			'{16'hebff, 16'h1400, ilcs_pkg::StatOk}},
		'{18'd20,   16'd19,   8'h00, 8'h00, 16'h0000, 1'b0, 1'b1,
			'{16'hecff, 16'h0000, ilcs_pkg::StatShortLen}},
		'{18'd21,   16'd22,   8'h00, 8'h00, 16'h0000, 1'b0, 1'b1,
			'{16'he9ff, 16'h1600, ilcs_pkg::StatShortStr}},
		'{18'd22,   16'd22,   ilcs_pkg::ProtoUdp, 8'h00, 16'h2700, 1'b0, 1'b1,
			'{16'hd8ff, 16'hffff, ilcs_pkg::StatOk}},
		'{18'd22,   16'd22,   8'h06, 8'h00, 16'h1c00, 1'b0, 1'b1,
			'{16'he3ff, 16'h0000, ilcs_pkg::StatOk}},
		'{18'd2,    16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd3,    16'hab00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd19,   16'h0030, 8'h06, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd4,    16'h0013, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd33,   16'd33,   ilcs_pkg::ProtoUdp, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd40,   16'd30,   8'h06, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd41,   16'd31,   ilcs_pkg::ProtoUdp, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd60,   16'd60,   8'hff, 8'hff, 16'hffff, 1'b0, 1'b0, '0},
		'{18'd64,   16'd64,   8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, '0},
		'{18'd300,  16'd300,  8'h06, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd100,  16'hffff, ilcs_pkg::ProtoUdp, 8'h00, 16'h0000, 1'b1, 1'b0, '0},
		'{18'd21,   16'd20,   ilcs_pkg::ProtoUdp, 8'h00, 16'h0000, 1'b0, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last      = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] header_checksum;
	logic [15:0] l4_checksum;
	logic [1:0]  status;

	// held alongside the beat on the bus
	logic        cur_typed = 1'b0;
	csum_t       cur_want  = '0;

	byte_beat_t  packet_bytes [$];
	csum_t       checksums_due [$];
	int unsigned cyc       = 0;
	int unsigned fail_cnt  = 0;

	// predictor's copy of the block state; zero matches the reset state
	logic [ilcs_pkg::CountW-1:0] cnt_q   = '0;
	logic [ilcs_pkg::HsumW-1:0]  hsum_q  = '0;
	logic [ilcs_pkg::PsumW-1:0]  psum_q  = '0;
	logic [7:0]                  pend_q  = '0;
	logic [15:0]                 tlen_q  = '0;
	logic [7:0]                  proto_q = '0;

	ipv4_l4_checksum_stream uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.header_checksum (header_checksum),
		.l4_checksum     (l4_checksum),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturating add; the 33-bit sum catches both overflow and the cap.
	function automatic logic [ilcs_pkg::PsumW-1:0] sat_add(
			input logic [ilcs_pkg::PsumW-1:0] a,
			input logic [ilcs_pkg::PsumW-1:0] b,
			input logic [ilcs_pkg::PsumW-1:0] lim);
		logic [ilcs_pkg::PsumW:0] r;
		r = {1'b0, a} + {1'b0, b};
		return (r > {1'b0, lim}) ? lim : r[ilcs_pkg::PsumW-1:0];
	endfunction

	// End-around carry fold of a 32-bit sum down to 16 bits, done twice.
	function automatic logic [15:0] fold_carry(input logic [31:0] s);
		logic [31:0] t;
		t = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
		t = {16'h0000, t[31:16]} + {16'h0000, t[15:0]};
		return t[15:0];
	endfunction

	// Fold one accepted byte into the running sums; on the last byte of a
	// packet, finish both checksums and clear the state for the next one.
	task automatic fold_packet_byte(input logic [7:0] b, input logic lst,
			output logic got, output csum_t res);
		logic [ilcs_pkg::CountW-1:0] pos;
		logic [ilcs_pkg::CountW-1:0] n;
		logic [ilcs_pkg::CountW-1:0] hn;
		logic [ilcs_pkg::CountW-1:0] m;
		logic [31:0]                 acc;
		logic [15:0]                 hdr;
		logic [15:0]                 l4;
		logic [1:0]                  st;
		pos = cnt_q;
		got = 1'b0;
		res = '0;
		if (pos < ilcs_pkg::HdrBytes) begin
			if (pos == ilcs_pkg::PosLenHi)
				tlen_q[15:8] = b;
			else if (pos == ilcs_pkg::PosLenLo)
				tlen_q[7:0] = b;
			else if (pos == ilcs_pkg::PosProto)
				proto_q = b;
			if (!pos[0])
				pend_q = b;
			else
				hsum_q = ilcs_pkg::HsumW'(sat_add(ilcs_pkg::PsumW'(hsum_q),
					ilcs_pkg::PsumW'({b, pend_q}), ilcs_pkg::PsumW'(ilcs_pkg::HsumMax)));
		end else if (pos < {1'b0, tlen_q}) begin
			m = pos - ilcs_pkg::HdrBytes;
			if (!m[0])
				pend_q = b;
			else
				psum_q = sat_add(psum_q, ilcs_pkg::PsumW'({b, pend_q}), ilcs_pkg::PsumMax);
		end
		if (cnt_q < ilcs_pkg::CountMax)
			cnt_q = cnt_q + 1'b1;
		if (lst) begin
			n = cnt_q;
			hn = (n < ilcs_pkg::HdrBytes) ? n : ilcs_pkg::HdrBytes;
			// unpaired header byte goes in as a low half
			if (hn[0])
				hsum_q = ilcs_pkg::HsumW'(sat_add(ilcs_pkg::PsumW'(hsum_q),
					ilcs_pkg::PsumW'(pend_q), ilcs_pkg::PsumW'(ilcs_pkg::HsumMax)));
			hdr = ~fold_carry(ilcs_pkg::PsumW'(hsum_q));
			if ({1'b0, tlen_q} < ilcs_pkg::HdrBytes) begin
				l4 = 16'h0000;
				st = ilcs_pkg::StatShortLen;
			end else begin
				if (n > ilcs_pkg::HdrBytes) begin
					m = ((n < {1'b0, tlen_q}) ? n : {1'b0, tlen_q}) - ilcs_pkg::HdrBytes;
					if (m[0])
						psum_q = sat_add(psum_q, ilcs_pkg::PsumW'(pend_q),
							ilcs_pkg::PsumMax);
				end
				acc = {16'h0000, fold_carry(psum_q)} + {16'h0000, hdr};
				acc = {16'h0000, acc[31:16]} + {16'h0000, acc[15:0]};
				l4 = ~acc[15:0];
				// a zero UDP checksum means "none", so it goes out as all ones
				if (l4 == 16'h0000 && proto_q == ilcs_pkg::ProtoUdp)
					l4 = 16'hffff;
				st = (n < {1'b0, tlen_q}) ? ilcs_pkg::StatShortStr : ilcs_pkg::StatOk;
			end
			res = '{hdr, l4, st};
			got = 1'b1;
			cnt_q = '0;
			hsum_q = '0;
			psum_q = '0;
			pend_q = '0;
			tlen_q = '0;
			proto_q = '0;
		end
	endtask

	// Queue one packet of beats; length and protocol bytes come from tl and pr.
	task automatic add_packet(input int len, input logic [15:0] tl, input logic [7:0] pr,
			input logic [7:0] hf, input logic [15:0] pw, input logic rnd,
			input logic typed, input csum_t want);
		byte_beat_t bt;
		for (int i = 0; i < len; i++) begin
			if (i < int'(ilcs_pkg::HdrBytes)) begin
				if (i == int'(ilcs_pkg::PosLenHi))
					bt.data = tl[15:8];
				else if (i == int'(ilcs_pkg::PosLenLo))
					bt.data = tl[7:0];
				else if (i == int'(ilcs_pkg::PosProto))
					bt.data = pr;
				else
					bt.data = rnd ? 8'($urandom) : hf;
			end else if (rnd) begin
				bt.data = 8'($urandom);
			end else begin
				bt.data = ((i - int'(ilcs_pkg::HdrBytes)) % 2 == 0) ? pw[7:0] : pw[15:8];
			end
			bt.lst = (i == len - 1);
			bt.typed = bt.lst && typed;
			bt.want = want;
			packet_bytes.push_back(bt);
		end
	endtask

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 2))
			0: return 8'h06;
			1: return ilcs_pkg::ProtoUdp;
			default: return 8'($urandom);
		endcase
	endfunction

	// Stimulus beats: push each accepted beat through the predictor, then
	// offer the next one unless this side idles.  Valid holds until taken.
	always @(posedge clk) begin
		logic        got;
		logic        quiet;
		csum_t       res;
		byte_beat_t  bt;
		cyc <= cyc + 1;
		quiet = (cyc >= QuietFrom) && (cyc < QuietTo);
		if (arst_n) begin
			if (in_valid && in_ready) begin
				fold_packet_byte(data_byte, last, got, res);
				if (got)
					checksums_due.push_back(cur_typed ? cur_want : res);
			end
			if (!in_valid || in_ready) begin
				if (packet_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
					bt = packet_bytes.pop_front();
					in_valid  <= 1'b1;
					data_byte <= bt.data;
					last      <= bt.lst;
					cur_typed <= bt.typed;
					cur_want  <= bt.want;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
		end
	end

	// Result beats: compare each one with the oldest checksum still due.
	always @(posedge clk) begin
		csum_t exp_sum;
		if (arst_n && out_valid && out_ready) begin
			if (checksums_due.size() == 0) begin
				$error("unexpected result beat: header_checksum %h l4_checksum %h status %0d",
					header_checksum, l4_checksum, status);
				fail_cnt = fail_cnt + 1;
			end else begin
				exp_sum = checksums_due.pop_front();
				if (header_checksum !== exp_sum.hdr) begin
					$error("header_checksum: expected %h, got %h", exp_sum.hdr, header_checksum);
					fail_cnt = fail_cnt + 1;
				end
				if (l4_checksum !== exp_sum.l4) begin
					$error("l4_checksum: expected %h, got %h", exp_sum.l4, l4_checksum);
					fail_cnt = fail_cnt + 1;
				end
				if (status !== exp_sum.st) begin
					$error("status: expected %0d, got %0d", exp_sum.st, status);
					fail_cnt = fail_cnt + 1;
				end
			end
		end
	end

	initial begin
		wait (cyc >= RunLimit);
		$display("ipv4_l4_checksum_stream verification failed");
		$finish;
	end

	initial begin
		int unsigned  rand_beats;
		int           len;
		int           kind;
		logic [15:0]  tl;
		rand_beats = 0;

		for (int r = 0; r < NumRows; r++)
			add_packet(int'(dir_rows[r].len), dir_rows[r].tl, dir_rows[r].pr, dir_rows[r].hf,
				dir_rows[r].pw, dir_rows[r].rnd, dir_rows[r].typed, dir_rows[r].want);

		// Mostly well-formed packets with random content; some overrun or cut
		// short, and some pure noise with a random length field.
		while (rand_beats < RandomBeats) begin
			kind = $urandom_range(0, 99);
			tl = 16'($urandom_range(20, 60));
			if ($urandom_range(0, 19) == 0)
				tl = 16'($urandom_range(61, 600));
			if (kind < 65) begin
				len = tl;
			end else if (kind < 75) begin
				len = tl + $urandom_range(1, 8);
			end else if (kind < 85) begin
				len = $urandom_range(1, tl - 1);
			end else begin
				tl = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
				len = $urandom_range(1, 40);
			end
			add_packet(len, tl, pick_proto(), 8'h00, 16'h0000, 1'b1, 1'b0, '0);
			rand_beats += len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (packet_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (checksums_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_cnt == 0)
			$display("ipv4_l4_checksum_stream verification clean");
		else
			$display("ipv4_l4_checksum_stream verification failed");
		$finish;
	end

endmodule
